// File: rtl/core/plfs_pkg.sv
// Package with the field widths, constants and register indexes of the line-following steering unit.
package plfs_pkg;

  localparam int unsigned PosW     = 12;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned DriveW   = 8;
  localparam int unsigned SteerW   = 9;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 32;

  localparam logic [PosW-1:0] LineMax    = 12'd4000;
  localparam logic [12:0]     LineCenter = 13'd2000;

  localparam logic [5:0] PropSteps  = 6'd11;
  localparam logic [5:0] IntegSteps = 6'd32;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CfgPropDivisor  = 3'd0;
  localparam cfg_idx_t CfgIntegDivisor = 3'd1;
  localparam cfg_idx_t CfgDerivGain    = 3'd2;
  localparam cfg_idx_t CfgLowSpeed     = 3'd3;
  localparam cfg_idx_t CfgHighSpeed    = 3'd4;
  localparam cfg_idx_t CfgBoostMs      = 3'd5;

endpackage

// File: rtl/core/pid_line_follow_steering_unit.sv
// PID steering controller for a line-following two-wheel drive, built around a shared divider.
// An accepted request passes through the states LOAD1, DIV1, LOAD2, DIV2, SUM and MIX to a registered result.
// The two quotients share one restoring divider: 11 steps for the error term, 32 for the integral.
// A new request is taken only once the result is registered; a stalled output holds the unit in MIX.
// Reset (synchronous, active low) restores the register defaults and clears the PID state.
module pid_line_follow_steering_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // line_position [11:0], elapsed_ms [43:12], zero [47:44]
  input  logic [plfs_pkg::InDataW-1:0]     in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // left_drive [7:0], right_drive [15:8], steer [24:16], zero [31:25]
  output logic [plfs_pkg::OutDataW-1:0]    out_tdata,
  input  logic                             cfg_we,
  input  logic [plfs_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [plfs_pkg::CfgDataW-1:0]    cfg_wdata
);
  import plfs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD1 = 3'd1;
  localparam logic [2:0] S_DIV1  = 3'd2;
  localparam logic [2:0] S_LOAD2 = 3'd3;
  localparam logic [2:0] S_DIV2  = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;
  localparam logic [2:0] S_MIX   = 3'd6;

  logic [14:0] prop_div_r;
  logic [15:0] integ_div_r;
  logic [15:0] deriv_gain_r;
  logic [7:0]  low_speed_r;
  logic [7:0]  high_speed_r;
  logic [31:0] boost_ms_r;

  logic [2:0]         state_r;
  logic signed [11:0] prev_error_r;
  logic signed [31:0] error_sum_r;
  logic signed [11:0] err_r;
  logic signed [12:0] deriv_r;
  logic [7:0]         speed_r;
  logic signed [29:0] prod_r;
  logic [31:0]        dvd_r;
  logic [15:0]        rem_r;
  logic [5:0]         cnt_r;
  logic               neg_r;
  logic signed [11:0] q1_r;
  logic signed [32:0] q2_r;
  logic signed [34:0] steer_full_r;
  logic               out_valid_r;
  logic [7:0]         out_left_r;
  logic [7:0]         out_right_r;
  logic signed [8:0]  out_steer_r;

  logic               accept;
  logic [11:0]        pos_in;
  logic [31:0]        elapsed_in;
  logic [11:0]        pos_clip;
  logic signed [12:0] err_in;
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_sat;
  logic [15:0]        dsr;
  logic [17:0]        trial;
  logic               borrow;
  logic [15:0]        rem_nxt;
  logic [31:0]        dvd_nxt;
  logic [31:0]        sum_mag;
  logic signed [33:0] qsum;
  logic signed [42:0] total;
  logic signed [34:0] steer_full_nxt;
  logic signed [34:0] spd;
  logic signed [34:0] steer_clamp;
  logic signed [8:0]  steer_nxt;
  logic               out_free;

  assign accept     = in_tvalid && in_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign pos_in     = in_tdata[11:0];
  assign elapsed_in = in_tdata[43:12];
  assign pos_clip   = (pos_in > LineMax) ? LineMax : pos_in;
  assign err_in     = $signed({1'b0, pos_clip}) - $signed(LineCenter);
  assign sum_wide   = 33'(error_sum_r) + 33'(err_in);

  always_comb begin
    if (sum_wide > 33'sh07FFFFFFF) begin
      sum_sat = 32'sh7FFFFFFF;
    end else if (sum_wide < -33'sh080000000) begin
      sum_sat = 32'sh80000000;
    end else begin
      sum_sat = 32'(sum_wide);
    end
  end

  assign dsr     = (state_r == S_DIV1) ? {1'b0, prop_div_r} : integ_div_r;
  assign trial   = {1'b0, rem_r, dvd_r[31]} - {2'b00, dsr};
  assign borrow  = trial[17];
  assign rem_nxt = borrow ? {rem_r[14:0], dvd_r[31]} : trial[15:0];
  assign dvd_nxt = {dvd_r[30:0], ~borrow};
  assign sum_mag = error_sum_r[31] ? 32'(-error_sum_r) : 32'(error_sum_r);

  assign qsum  = 34'(q1_r) + 34'(q2_r);
  assign total = (43'(qsum) <<< 8) + 43'(prod_r);
  assign steer_full_nxt = 35'(total >>> 8)
                        + $signed({34'b0, (total[42] && (total[7:0] != 8'd0))});

  assign spd = $signed({27'b0, speed_r});

  always_comb begin
    if (steer_full_r > spd) begin
      steer_clamp = spd;
    end else if (steer_full_r < -spd) begin
      steer_clamp = -spd;
    end else begin
      steer_clamp = steer_full_r;
    end
  end

  assign steer_nxt = 9'(steer_clamp);
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_div_r   <= 15'd1;
      integ_div_r  <= 16'd10000;
      deriv_gain_r <= 16'd0;
      low_speed_r  <= 8'd60;
      high_speed_r <= 8'd100;
      boost_ms_r   <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgPropDivisor:  prop_div_r   <= cfg_wdata[14:0];
        CfgIntegDivisor: integ_div_r  <= cfg_wdata[15:0];
        CfgDerivGain:    deriv_gain_r <= cfg_wdata[15:0];
        CfgLowSpeed:     low_speed_r  <= cfg_wdata[7:0];
        CfgHighSpeed:    high_speed_r <= cfg_wdata[7:0];
        CfgBoostMs:      boost_ms_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      prev_error_r <= '0;
      error_sum_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (state_r == S_MIX && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            prev_error_r <= 12'(err_in);
            error_sum_r  <= sum_sat;
            state_r      <= S_LOAD1;
          end
        end
        S_LOAD1: state_r <= S_DIV1;
        S_DIV1: begin
          if (cnt_r == 6'd1) begin
            state_r <= S_LOAD2;
          end
        end
        S_LOAD2: state_r <= S_DIV2;
        S_DIV2: begin
          if (cnt_r == 6'd1) begin
            state_r <= S_SUM;
          end
        end
        S_SUM: state_r <= S_MIX;
        S_MIX: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          err_r   <= 12'(err_in);
          deriv_r <= err_in - 13'(prev_error_r);
          speed_r <= (elapsed_in >= boost_ms_r) ? low_speed_r : high_speed_r;
        end
      end
      S_LOAD1: begin
        prod_r <= 30'(deriv_r) * 30'($signed({1'b0, deriv_gain_r}));
        neg_r  <= err_r[11];
        dvd_r  <= {(err_r[11] ? 11'(-err_r) : 11'(err_r)), 21'b0};
        rem_r  <= '0;
        cnt_r  <= PropSteps;
      end
      S_DIV1: begin
        dvd_r <= dvd_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          if (prop_div_r == 15'd0) begin
            q1_r <= '0;
          end else if (neg_r) begin
            q1_r <= -$signed(12'(dvd_nxt[10:0]));
          end else begin
            q1_r <= $signed(12'(dvd_nxt[10:0]));
          end
        end
      end
      S_LOAD2: begin
        neg_r <= error_sum_r[31];
        dvd_r <= sum_mag;
        rem_r <= '0;
        cnt_r <= IntegSteps;
      end
      S_DIV2: begin
        dvd_r <= dvd_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          if (integ_div_r == 16'd0) begin
            q2_r <= '0;
          end else if (neg_r) begin
            q2_r <= -$signed({1'b0, dvd_nxt});
          end else begin
            q2_r <= $signed({1'b0, dvd_nxt});
          end
        end
      end
      S_SUM: steer_full_r <= steer_full_nxt;
      S_MIX: begin
        if (out_free) begin
          out_steer_r <= steer_nxt;
          if (steer_nxt[8]) begin
            out_left_r  <= speed_r + steer_nxt[7:0];
            out_right_r <= speed_r;
          end else begin
            out_left_r  <= speed_r;
            out_right_r <= speed_r - steer_nxt[7:0];
          end
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_steer_r, out_right_r, out_left_r};

`ifndef SYNTHESIS
  a_sum_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (!accept) |=> $stable(error_sum_r))
    else $error("integral changed without an accepted request");

  a_rem_below_prop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV1 && prop_div_r != 15'd0) |-> (rem_r < {1'b0, prop_div_r}))
    else $error("divider remainder not below the proportional divisor");

  a_rem_below_integ: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV2 && integ_div_r != 16'd0) |-> (rem_r < integ_div_r))
    else $error("divider remainder not below the integral divisor");

  a_mix_right: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_steer_r[8]) |-> (out_right_r + out_steer_r[7:0] == out_left_r))
    else $error("drive mix inconsistent with a right-hand steer");

  a_mix_left: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_steer_r[8]) |-> (out_left_r - out_steer_r[7:0] == out_right_r))
    else $error("drive mix inconsistent with a left-hand steer");
`endif

endmodule
